/* design/dtv_pkg.sv */
// shared types, constants and lookup functions for the date/time validator
package dtv_pkg;

    localparam logic [15:0] YEAR_MIN     = 16'd2000;
    localparam logic [15:0] YEAR_MAX     = 16'd2099;
    localparam logic [7:0]  YEAR_MIN_LO  = 8'd208;
    localparam logic [7:0]  HOUR_MAX     = 8'd23;
    localparam logic [7:0]  MINSEC_MAX   = 8'd59;
    localparam logic [7:0]  MONTH_MAX    = 8'd12;
    localparam logic [6:0]  LAST_YY      = 7'd99;
    localparam logic [4:0]  FEB_LEAP_LEN = 5'd29;

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_MAR = 4'd3;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_MAY = 4'd5;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_JUL = 4'd7;
    localparam logic [3:0] MON_AUG = 4'd8;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_OCT = 4'd10;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    typedef struct packed {
        logic [15:0] year_in;
        logic [7:0]  month_in;
        logic [7:0]  day_in;
        logic [7:0]  hour_in;
        logic [7:0]  minute_in;
        logic [7:0]  second_in;
    } dtv_in_t;

    typedef struct packed {
        logic       is_valid;
        logic       is_leap;
        logic [4:0] month_length;
        logic [2:0] weekday;
    } dtv_out_t;

    typedef struct packed {
        logic        year_ok;
        logic        clock_ok;
        logic        month_ok;
        logic        mod4;
        logic        mod16;
        logic [10:0] r25;
        logic [7:0]  yofs;
        logic [3:0]  month;
        logic [7:0]  day;
    } dtv_s1_t;

    typedef struct packed {
        logic       year_ok;
        logic       clock_ok;
        logic       month_ok;
        logic       mod4;
        logic       mod16;
        logic [8:0] r25;
        logic [8:0] wsum;
        logic [3:0] month;
        logic [7:0] day;
    } dtv_s2_t;

    typedef struct packed {
        logic       year_ok;
        logic       clock_ok;
        logic       month_ok;
        logic       mod4;
        logic       mod16;
        logic [6:0] r25;
        logic [3:0] wsum;
        logic [3:0] month;
        logic [7:0] day;
    } dtv_s3_t;

    // days in month for a common year, zero outside 1..12
    function automatic logic [4:0] base_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            MON_JAN, MON_MAR, MON_MAY, MON_JUL,
            MON_AUG, MON_OCT, MON_DEC:            len = 5'd31;
            MON_APR, MON_JUN, MON_SEP, MON_NOV:   len = 5'd30;
            MON_FEB:                              len = 5'd28;
            default:                              len = 5'd0;
        endcase
        return len;
    endfunction

    // (13*m + 8)/5 mod 7 with jan/feb taken as months 13 and 14
    function automatic logic [2:0] month_term(input logic [3:0] m);
        logic [2:0] t;
        unique case (m)
            MON_JAN: t = 3'd0;
            MON_FEB: t = 3'd3;
            MON_MAR: t = 3'd2;
            MON_APR: t = 3'd5;
            MON_MAY: t = 3'd0;
            MON_JUN: t = 3'd3;
            MON_JUL: t = 3'd5;
            MON_AUG: t = 3'd1;
            MON_SEP: t = 3'd4;
            MON_OCT: t = 3'd6;
            MON_NOV: t = 3'd2;
            MON_DEC: t = 3'd4;
            default: t = 3'd0;
        endcase
        return t;
    endfunction

endpackage

/* design/dtv_prep.sv */
// first stage: range checks, year residue setup and year offset
module dtv_prep
    import dtv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_vld,
    input  dtv_in_t item,
    output logic    s1_vld,
    output dtv_s1_t s1
);

    logic    vld_reg;
    dtv_s1_t s1_reg;
    dtv_s1_t s1_next;
    logic    early;

    always_comb
    begin
        early             = (item.month_in < 8'd3);
        s1_next.year_ok   = (item.year_in >= YEAR_MIN) && (item.year_in <= YEAR_MAX);
        s1_next.clock_ok  = (item.hour_in <= HOUR_MAX) && (item.minute_in <= MINSEC_MAX)
                            && (item.second_in <= MINSEC_MAX);
        s1_next.month_ok  = (item.month_in != 8'd0) && (item.month_in <= MONTH_MAX);
        s1_next.mod4      = (item.year_in[1:0] == 2'd0);
        s1_next.mod16     = (item.year_in[3:0] == 4'd0);
        // 256 = 6 mod 25
        s1_next.r25       = ({3'b0, item.year_in[15:8]} * 11'd6) + {3'b0, item.year_in[7:0]};
        s1_next.yofs      = item.year_in[7:0] - YEAR_MIN_LO - {7'b0, early};
        s1_next.month     = item.month_in[3:0];
        s1_next.day       = item.day_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1_vld = vld_reg;
    assign s1     = s1_reg;

endmodule

/* design/dtv_reduce.sv */
// second and third stages: residue folding for mod 25 and the weekday sum
module dtv_reduce
    import dtv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s1_vld,
    input  dtv_s1_t s1,
    output logic    s3_vld,
    output dtv_s3_t s3
);

    logic    s2_vld_reg;
    dtv_s2_t s2_reg;
    dtv_s2_t s2_next;
    logic    s3_vld_reg;
    dtv_s3_t s3_reg;
    dtv_s3_t s3_next;
    logic    prev_century;
    logic [6:0] yy;
    logic [5:0] wfold;

    always_comb
    begin
        prev_century     = (s1.yofs == 8'hFF);
        yy               = prev_century ? LAST_YY : s1.yofs[6:0];
        s2_next.year_ok  = s1.year_ok;
        s2_next.clock_ok = s1.clock_ok;
        s2_next.month_ok = s1.month_ok;
        s2_next.mod4     = s1.mod4;
        s2_next.mod16    = s1.mod16;
        // 64 = 14 mod 25
        s2_next.r25      = ({4'b0, s1.r25[10:6]} * 9'd14) + {3'b0, s1.r25[5:0]};
        // century term is 1 for the 1900s and 0 for the 2000s
        s2_next.wsum     = {8'b0, prev_century} + {2'b0, yy} + {4'b0, yy[6:2]}
                           + {6'b0, month_term(s1.month)} + {1'b0, s1.day};
        s2_next.month    = s1.month;
        s2_next.day      = s1.day;
    end

    always_comb
    begin
        // 8 = 1 mod 7
        wfold            = s2_reg.wsum[8:3] + {3'b0, s2_reg.wsum[2:0]};
        s3_next.year_ok  = s2_reg.year_ok;
        s3_next.clock_ok = s2_reg.clock_ok;
        s3_next.month_ok = s2_reg.month_ok;
        s3_next.mod4     = s2_reg.mod4;
        s3_next.mod16    = s2_reg.mod16;
        // 32 = 7 mod 25
        s3_next.r25      = ({3'b0, s2_reg.r25[8:5]} * 7'd7) + {2'b0, s2_reg.r25[4:0]};
        s3_next.wsum     = {1'b0, wfold[5:3]} + {1'b0, wfold[2:0]};
        s3_next.month    = s2_reg.month;
        s3_next.day      = s2_reg.day;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_vld)
        begin
            s2_reg <= s2_next;
        end
        if (s2_vld_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign s3_vld = s3_vld_reg;
    assign s3     = s3_reg;

endmodule

/* design/dtv_final.sv */
// last stage: leap decision, month length, day check and result register
module dtv_final
    import dtv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s3_vld,
    input  dtv_s3_t  s3,
    output logic     done,
    output dtv_out_t result
);

    logic     done_reg;
    dtv_out_t result_reg;
    dtv_out_t result_next;
    logic     div25;
    logic     leap;
    logic [4:0] mlen;
    logic     valid;
    logic [3:0] wdiff;
    logic [2:0] wday;

    always_comb
    begin
        div25 = (s3.r25 == 7'd0) || (s3.r25 == 7'd25) || (s3.r25 == 7'd50)
                || (s3.r25 == 7'd75) || (s3.r25 == 7'd100);
        leap  = s3.mod4 && (!div25 || s3.mod16);
        if (!s3.month_ok)
        begin
            mlen = 5'd0;
        end
        else if ((s3.month == MON_FEB) && leap)
        begin
            mlen = FEB_LEAP_LEN;
        end
        else
        begin
            mlen = base_len(s3.month);
        end
        valid = s3.year_ok && s3.month_ok && s3.clock_ok
                && (s3.day != 8'd0) && (s3.day <= {3'b0, mlen});
        wdiff = s3.wsum - 4'd7;
        wday  = (s3.wsum >= 4'd7) ? wdiff[2:0] : s3.wsum[2:0];
        result_next.is_valid     = valid;
        result_next.is_leap      = leap;
        result_next.month_length = mlen;
        result_next.weekday      = valid ? wday : 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_vld)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_wday_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.weekday <= 3'd6))
        else $error("weekday out of range");

    a_invalid_wday: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.is_valid) |-> (result.weekday == 3'd0))
        else $error("weekday set on invalid date");

    a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_valid) |-> (result.month_length >= 5'd28))
        else $error("valid date with short month length");

    a_leap_feb: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.month_length == FEB_LEAP_LEN)) |-> result.is_leap)
        else $error("leap february length without leap year");

endmodule

/* design/datetime_validate_weekday.sv */
// top level of the calendar date and time validator with weekday
// the accepted date passes the s1, s2 and s3 registers, and done rises as the result register loads
// throughput: one transaction per cycle, a four-stage pipeline of range checks and residue folds
// busy stays low, results are strobed for one cycle and the receiver cannot stall them
// reset clears only the stage valid flags and done, payload registers are not reset
module datetime_validate_weekday
    import dtv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  dtv_in_t  item,
    output logic     done,
    output dtv_out_t result
);

    logic    accept;
    logic    s1_vld;
    dtv_s1_t s1;
    logic    s3_vld;
    dtv_s3_t s3;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    dtv_prep u_prep (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (accept),
        .item   (item),
        .s1_vld (s1_vld),
        .s1     (s1)
    );

    dtv_reduce u_reduce (
        .clk    (clk),
        .rst_n  (rst_n),
        .s1_vld (s1_vld),
        .s1     (s1),
        .s3_vld (s3_vld),
        .s3     (s3)
    );

    dtv_final u_final (
        .clk    (clk),
        .rst_n  (rst_n),
        .s3_vld (s3_vld),
        .s3     (s3),
        .done   (done),
        .result (result)
    );

endmodule

/* bench/dtv_checker.sv */
// checker for the date validator: predicts each verdict and compares it with the strobed result
`timescale 1ns / 100ps

module dtv_checker
    import dtv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  dtv_in_t  item,
    input  logic     done,
    input  dtv_out_t result,
    output int       fail_count,
    output int       pending,
    output int       dates_seen,
    output int       valid_seen
);

    typedef struct packed {
        dtv_in_t  date;
        dtv_out_t verdict;
    } graded_date_t;

    graded_date_t verdict_q[$];
    int fails = 0;
    int seen  = 0;
    int valid = 0;

    function automatic logic leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic logic [4:0] month_len_of(input int unsigned y, input int unsigned m);
        logic [4:0] n;
        unique case (m)
            MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: n = 5'd31;
            MON_APR, MON_JUN, MON_SEP, MON_NOV:                           n = 5'd30;
            MON_FEB: n = leap_year(y) ? FEB_LEAP_LEN : 5'd28;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic dtv_out_t judge_date(input dtv_in_t d);
        dtv_out_t    r;
        int unsigned y;
        int unsigned m;
        int unsigned c;
        logic        ok;
        r.is_leap      = leap_year(d.year_in);
        r.month_length = month_len_of(d.year_in, d.month_in);
        ok = d.year_in >= YEAR_MIN && d.year_in <= YEAR_MAX &&
             d.month_in >= MON_JAN && d.month_in <= MONTH_MAX &&
             d.day_in >= 8'd1 && d.day_in <= r.month_length &&
             d.hour_in <= HOUR_MAX && d.minute_in <= MINSEC_MAX &&
             d.second_in <= MINSEC_MAX;
        r.is_valid = ok;
        r.weekday  = 3'd0;
        if (ok)
        begin
            y = d.year_in;
            m = d.month_in;
            // jan and feb count as months 13 and 14 of the previous year
            if (m < MON_MAR)
            begin
                y = y - 1;
                m = m + 12;
            end
            c = y / 100;
            r.weekday = 3'((y + y / 4 - c + c / 4 + (13 * m + 8) / 5 + d.day_in) % 7);
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        graded_date_t oldest;
        graded_date_t fresh;
        if (rst_n)
        begin
            if (done)
            begin
                if (verdict_q.size() == 0)
                begin
                    fails = fails + 1;
                    if (fails <= 10)
                        $display("[%0t] result with no transaction pending: %p", $realtime, result);
                end
                else
                begin
                    oldest = verdict_q.pop_front();
                    if (result.is_valid !== oldest.verdict.is_valid ||
                        result.is_leap !== oldest.verdict.is_leap ||
                        result.month_length !== oldest.verdict.month_length ||
                        result.weekday !== oldest.verdict.weekday)
                    begin
                        fails = fails + 1;
                        if (fails <= 10)
                        begin
                            $write("[%0t] %0d-%0d-%0d %0d:%0d:%0d",
                                   $realtime, oldest.date.year_in, oldest.date.month_in,
                                   oldest.date.day_in, oldest.date.hour_in,
                                   oldest.date.minute_in, oldest.date.second_in);
                            $display(" exp v%0b l%0b len%0d wd%0d got v%0b l%0b len%0d wd%0d",
                                     oldest.verdict.is_valid, oldest.verdict.is_leap,
                                     oldest.verdict.month_length, oldest.verdict.weekday,
                                     result.is_valid, result.is_leap,
                                     result.month_length, result.weekday);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                fresh.date    = item;
                fresh.verdict = judge_date(item);
                verdict_q.push_back(fresh);
                seen = seen + 1;
                if (fresh.verdict.is_valid)
                    valid = valid + 1;
            end
            fail_count <= fails;
            pending    <= verdict_q.size();
            dates_seen <= seen;
            valid_seen <= valid;
        end
    end

endmodule

/* bench/tb_top.sv */
// top of the date validator testbench: clock, reset, date stimulus and verdict
`timescale 1ns / 100ps

module tb_top;
    import dtv_pkg::*;

    localparam int RANDOM_DATES = 1950;
    localparam int CALM_TAIL    = 300;
    localparam int IN_BITS      = $bits(dtv_in_t);

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     done;
    dtv_in_t  item;
    dtv_out_t result;
    int       fail_count;
    int       pending;
    int       dates_seen;
    int       valid_seen;

    datetime_validate_weekday i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    dtv_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending),
        .dates_seen (dates_seen),
        .valid_seen (valid_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("timeout with %0d transactions outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic dtv_in_t make_date(input int y, input int m, input int d,
                                          input int h, input int mi, input int s);
        dtv_in_t t;
        t.year_in   = 16'(y);
        t.month_in  = 8'(m);
        t.day_in    = 8'(d);
        t.hour_in   = 8'(h);
        t.minute_in = 8'(mi);
        t.second_in = 8'(s);
        return t;
    endfunction

    // mostly in range, now and then any 8-bit value
    function automatic logic [7:0] field_pick(input int lo, input int hi);
        if ($urandom_range(99) < 7)
            return 8'($urandom);
        return 8'($urandom_range(hi, lo));
    endfunction

    function automatic dtv_in_t random_date();
        dtv_in_t t;
        int      roll;
        roll = $urandom_range(99);
        if (roll < 80)
            t.year_in = 16'($urandom_range(2099, 2000));
        else if (roll < 90)
            t.year_in = 16'($urandom);
        else
            t.year_in = 16'($urandom_range(2110, 1990));
        t.month_in  = field_pick(1, 12);
        t.day_in    = field_pick(1, 31);
        t.hour_in   = field_pick(0, 23);
        t.minute_in = field_pick(0, 59);
        t.second_in = field_pick(0, 59);
        return t;
    endfunction

    task automatic send_date(input dtv_in_t d, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(3, 1);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
                item  <= IN_BITS'({$urandom, $urandom});
            end
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= d;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        dtv_in_t corner_dates[$];
        int      common_len[12];
        common_len = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        start = 1'b0;
        item  = '0;
        rst_n = 1'b0;

        corner_dates.push_back(make_date(2099, 12, 31, 23, 59, 59));
        corner_dates.push_back(make_date(1999, 12, 31, 12, 0, 0));
        corner_dates.push_back(make_date(2100, 2, 28, 0, 0, 0));
        corner_dates.push_back(make_date(0, 0, 0, 0, 0, 0));
        corner_dates.push_back(make_date(65535, 255, 255, 255, 255, 255));
        corner_dates.push_back(make_date(2000, 2, 29, 6, 30, 0));
        corner_dates.push_back(make_date(2001, 2, 29, 6, 30, 0));
        corner_dates.push_back(make_date(2024, 0, 10, 1, 1, 1));
        corner_dates.push_back(make_date(2024, 13, 10, 1, 1, 1));
        corner_dates.push_back(make_date(2023, 4, 31, 8, 0, 0));
        corner_dates.push_back(make_date(2023, 6, 0, 8, 0, 0));
        corner_dates.push_back(make_date(2050, 7, 15, 24, 0, 0));
        corner_dates.push_back(make_date(2050, 7, 15, 0, 60, 0));
        corner_dates.push_back(make_date(2050, 7, 15, 0, 0, 60));
        corner_dates.push_back(make_date(1600, 2, 29, 0, 0, 0));
        for (int m = 1; m <= 12; m++)
            corner_dates.push_back(make_date(2020 + m, m, common_len[m - 1], m, m * 4, 59 - m));

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (corner_dates[i])
            send_date(corner_dates[i], 1'b1);
        for (int n = 0; n < RANDOM_DATES; n++)
            send_date(random_date(), n < RANDOM_DATES - CALM_TAIL);

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d dates checked (%0d valid), corners plus random fields with input gaps",
                 dates_seen, valid_seen);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
